// File: rtl/core/vector_cosine_similarity_top_defines.svh
// Assertion shorthands; the including module supplies clk and arst_n.
`ifndef VECTOR_COSINE_SIMILARITY_TOP_DEFINES_SVH
`define VECTOR_COSINE_SIMILARITY_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VCS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/vcs_pkg.sv
package vcs_pkg;

	localparam int ELEM_W      = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int DOT_W       = 44;
	localparam int ENERGY_W    = 43;
	localparam int SIM_W       = 16;
	localparam int ONE_Q14     = 16384;
	localparam int MAX_LEN_DEF = 4096;

	// shared adder: holds M^2 (88 bits) and the shifted remainder
	localparam int ALU_W      = 2 * DOT_W + 1;
	// quotient bits of (M^2 << 30) / P, saturating
	localparam int QUO_W      = 31;
	localparam int SQRT_STEPS = (QUO_W + 1) / 2;

	localparam logic signed [SIM_W-1:0] SIM_MAX = SIM_W'(ONE_Q14);
	localparam logic signed [SIM_W-1:0] SIM_MIN = -SIM_W'(ONE_Q14);

	typedef struct packed {
		logic [DOT_W-1:0]    dot;
		logic [ENERGY_W-1:0] x_energy;
		logic [ENERGY_W-1:0] y_energy;
		logic                too_long;
	} vcs_snap_t;

	typedef struct packed {
		logic signed [SIM_W-1:0] similarity;
		logic                    zero_norm;
		logic                    too_long;
	} vcs_res_t;

endpackage

// File: rtl/core/vcs_in_if.sv
interface vcs_in_if import vcs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] x_elem;
	logic signed [ELEM_W-1:0] y_elem;
	logic                     is_last;

	modport source (output valid, output x_elem, output y_elem, output is_last, input ready);
	modport sink (input valid, input x_elem, input y_elem, input is_last, output ready);
endinterface

// File: rtl/core/vcs_out_if.sv
interface vcs_out_if import vcs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SIM_W-1:0] similarity;
	logic                    zero_norm;
	logic                    too_long;

	modport source (output valid, output similarity, output zero_norm, output too_long,
		input ready);
	modport sink (input valid, input similarity, input zero_norm, input too_long,
		output ready);
endinterface

// File: rtl/core/vcs_addsub.sv
module vcs_addsub import vcs_pkg::*; (
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	input  logic             sub,
	output logic [ALU_W-1:0] sum,
	output logic             carry
);

	logic [ALU_W:0] full;

	// carry out on subtract means a >= b
	assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
	assign sum   = full[ALU_W-1:0];
	assign carry = full[ALU_W];

endmodule

// File: rtl/core/vcs_accum.sv
module vcs_accum import vcs_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vcs_in_if.sink    samples,
	output logic      hand_valid,
	input  logic      hand_ready,
	output vcs_snap_t snap
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_DOT  = 3'd1;
	localparam logic [2:0] A_XE   = 3'd2;
	localparam logic [2:0] A_YE   = 3'd3;
	localparam logic [2:0] A_HAND = 3'd4;

	logic [2:0]                    state_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                          last_q;
	logic                          skip_q;
	logic [DOT_W-1:0]              dot_q;
	logic [ENERGY_W-1:0]           xe_q;
	logic [ENERGY_W-1:0]           ye_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          ovf_q;

	logic signed [SAMPLE_BITS-1:0] op_a;
	logic signed [SAMPLE_BITS-1:0] op_b;
	logic signed [PROD_W-1:0]      prod;
	logic [DOT_W-1:0]              prod_ext;
	logic [DOT_W-1:0]              acc_cur;
	logic [DOT_W-1:0]              acc_sum;
	logic                          take;
	logic                          full_len;

	assign samples.ready = (state_q == A_IDLE);
	assign take          = samples.valid && samples.ready;
	assign full_len      = (cnt_q >= CNT_W'(MAX_LEN));

	assign hand_valid = (state_q == A_HAND);
	assign snap       = '{dot: dot_q, x_energy: xe_q, y_energy: ye_q, too_long: ovf_q};

	// one multiplier, one product per cycle: x*y, then x*x, then y*y
	always_comb begin
		unique case (state_q)
			A_DOT: begin
				op_a    = x_q;
				op_b    = y_q;
				acc_cur = dot_q;
			end
			A_XE: begin
				op_a    = x_q;
				op_b    = x_q;
				acc_cur = {{(DOT_W-ENERGY_W){1'b0}}, xe_q};
			end
			default: begin
				op_a    = y_q;
				op_b    = y_q;
				acc_cur = {{(DOT_W-ENERGY_W){1'b0}}, ye_q};
			end
		endcase
	end

	assign prod     = op_a * op_b;
	assign prod_ext = {{(DOT_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign acc_sum  = acc_cur + prod_ext;

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= samples.x_elem[SAMPLE_BITS-1:0];
			y_q <= samples.y_elem[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			last_q  <= 1'b0;
			skip_q  <= 1'b0;
			dot_q   <= '0;
			xe_q    <= '0;
			ye_q    <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (take) begin
						last_q  <= samples.is_last;
						skip_q  <= full_len;
						state_q <= A_DOT;
						// drop pairs beyond the length limit, remember that it happened
						if (full_len) begin
							ovf_q <= 1'b1;
						end
					end
				end
				A_DOT: begin
					if (!skip_q) begin
						dot_q <= acc_sum;
					end
					state_q <= A_XE;
				end
				A_XE: begin
					if (!skip_q) begin
						xe_q <= acc_sum[ENERGY_W-1:0];
					end
					state_q <= A_YE;
				end
				A_YE: begin
					if (!skip_q) begin
						ye_q  <= acc_sum[ENERGY_W-1:0];
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= last_q ? A_HAND : A_IDLE;
				end
				A_HAND: begin
					// hold the sums until the divider takes them, then clear
					if (hand_ready) begin
						dot_q   <= '0;
						xe_q    <= '0;
						ye_q    <= '0;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= A_IDLE;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/vcs_final.sv
module vcs_final import vcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      hand_valid,
	output logic      hand_ready,
	input  vcs_snap_t snap,
	output logic      res_valid,
	input  logic      res_ready,
	output vcs_res_t  res
);

	localparam int CNT_W = $clog2(DOT_W);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MULP = 3'd1;
	localparam logic [2:0] F_MULM = 3'd2;
	localparam logic [2:0] F_CMP  = 3'd3;
	localparam logic [2:0] F_DIV  = 3'd4;
	localparam logic [2:0] F_SQRT = 3'd5;
	localparam logic [2:0] F_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ALU_W-1:0] acc_q;
	logic [ALU_W-1:0] mcand_q;
	logic [ALU_W-1:0] p_q;
	logic [DOT_W-1:0] mplier_q;
	logic [DOT_W-1:0] mag_q;
	logic [QUO_W-1:0] quo_q;
	logic [QUO_W-1:0] root_q;
	logic [QUO_W-1:0] bit_q;
	logic             first_q;
	logic             neg_q;
	logic             zero_q;
	logic             long_q;

	logic [ALU_W-1:0] ua;
	logic [ALU_W-1:0] ub;
	logic             usub;
	logic [ALU_W-1:0] usum;
	logic             ucarry;
	logic [ALU_W-1:0] div_a;
	logic [DOT_W-1:0] mag_in;
	logic             zero_in;
	logic [QUO_W:0]   rnd;
	logic [QUO_W-1:0] half;
	logic [SIM_W-1:0] q_mag;
	logic [SIM_W-1:0] q_signed;

	assign hand_ready = (state_q == F_IDLE);
	assign res_valid  = (state_q == F_DONE);

	assign mag_in  = snap.dot[DOT_W-1] ? (~snap.dot + DOT_W'(1)) : snap.dot;
	assign zero_in = (snap.x_energy == '0) || (snap.y_energy == '0);
	assign div_a   = first_q ? acc_q : {acc_q[ALU_W-2:0], 1'b0};

	always_comb begin
		unique case (state_q)
			F_MULP, F_MULM: begin
				ua   = acc_q;
				ub   = mplier_q[0] ? mcand_q : '0;
				usub = 1'b0;
			end
			F_CMP: begin
				ua   = acc_q;
				ub   = {p_q[ALU_W-2:0], 1'b0};
				usub = 1'b1;
			end
			F_DIV: begin
				ua   = div_a;
				ub   = p_q;
				usub = 1'b1;
			end
			F_SQRT: begin
				ua   = {{(ALU_W-QUO_W){1'b0}}, quo_q};
				ub   = {{(ALU_W-QUO_W){1'b0}}, (root_q | bit_q)};
				usub = 1'b1;
			end
			default: begin
				ua   = acc_q;
				ub   = '0;
				usub = 1'b0;
			end
		endcase
	end

	vcs_addsub u_addsub (
		.a     (ua),
		.b     (ub),
		.sub   (usub),
		.sum   (usum),
		.carry (ucarry)
	);

	// q = min(1.0, (isqrt(D) + 1) / 2), D = floor(dot^2 * 2^30 / (ex * ey))
	assign rnd      = {1'b0, root_q} + (QUO_W+1)'(1);
	assign half     = rnd[QUO_W:1];
	assign q_mag    = (half > QUO_W'(ONE_Q14)) ? SIM_W'(ONE_Q14) : half[SIM_W-1:0];
	assign q_signed = neg_q ? (~q_mag + SIM_W'(1)) : q_mag;

	assign res = '{similarity: (zero_q ? '0 : $signed(q_signed)),
		zero_norm: zero_q, too_long: long_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (hand_valid) begin
					neg_q    <= snap.dot[DOT_W-1];
					mag_q    <= mag_in;
					long_q   <= snap.too_long;
					acc_q    <= '0;
					mcand_q  <= {{(ALU_W-ENERGY_W){1'b0}}, snap.x_energy};
					mplier_q <= {{(DOT_W-ENERGY_W){1'b0}}, snap.y_energy};
					cnt_q    <= CNT_W'(ENERGY_W - 1);
				end
			end
			F_MULP: begin
				if (cnt_q == '0) begin
					p_q      <= usum;
					acc_q    <= '0;
					mcand_q  <= {{(ALU_W-DOT_W){1'b0}}, mag_q};
					mplier_q <= mag_q;
					cnt_q    <= CNT_W'(DOT_W - 1);
				end else begin
					acc_q    <= usum;
					mcand_q  <= {mcand_q[ALU_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[DOT_W-1:1]};
					cnt_q    <= cnt_q - CNT_W'(1);
				end
			end
			F_MULM: begin
				acc_q    <= usum;
				mcand_q  <= {mcand_q[ALU_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[DOT_W-1:1]};
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			F_CMP: begin
				// quotient would reach 2^31: saturate, the result clamps anyway
				if (ucarry) begin
					quo_q  <= '1;
					root_q <= '0;
					bit_q  <= {1'b1, {(QUO_W-1){1'b0}}};
					cnt_q  <= CNT_W'(SQRT_STEPS - 1);
				end else begin
					quo_q   <= '0;
					first_q <= 1'b1;
					cnt_q   <= CNT_W'(QUO_W - 1);
				end
			end
			F_DIV: begin
				first_q <= 1'b0;
				acc_q   <= ucarry ? usum : div_a;
				quo_q   <= {quo_q[QUO_W-2:0], ucarry};
				if (cnt_q == '0) begin
					root_q <= '0;
					bit_q  <= {1'b1, {(QUO_W-1){1'b0}}};
					cnt_q  <= CNT_W'(SQRT_STEPS - 1);
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			F_SQRT: begin
				if (ucarry) begin
					quo_q  <= usum[QUO_W-1:0];
					root_q <= {1'b0, root_q[QUO_W-1:1]} | bit_q;
				end else begin
					root_q <= {1'b0, root_q[QUO_W-1:1]};
				end
				bit_q <= {2'b00, bit_q[QUO_W-1:2]};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (hand_valid) begin
						zero_q  <= zero_in;
						state_q <= zero_in ? F_DONE : F_MULP;
					end
				end
				F_MULP: begin
					if (cnt_q == '0) begin
						state_q <= F_MULM;
					end
				end
				F_MULM: begin
					if (cnt_q == '0) begin
						state_q <= F_CMP;
					end
				end
				F_CMP: begin
					state_q <= ucarry ? F_SQRT : F_DIV;
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_SQRT;
					end
				end
				F_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (res_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/vector_cosine_similarity_top.sv
// Streaming cosine similarity of two vectors of signed 16-bit samples.
// samples: one element pair per item (x_elem, y_elem, is_last). Each pair
// occupies the accumulator: ready drops while a single multiplier forms
// x*y, x*x and y*y in turn and adds them in.
// results: one item per vector, produced by the pair marked is_last:
// similarity in Q2.14 (16384 = 1.0, rounded, clamped), zero_norm when either
// vector is all zeros, too_long when more than MAX_LEN pairs arrived (only
// the first MAX_LEN are summed).
// From the last pair to results.valid the work runs as accumulation,
// hand-off, 43 + 44 shift-add steps for ex*ey and dot^2, 1 range check,
// 31 restoring divide steps and 16 square root steps, all on one shared
// 89-bit adder. A zero-norm vector skips the arithmetic steps.
// Pairs of the next vector are accepted while that runs; its last pair
// waits in the accumulator until the divider is free.
// Reset empties the output register and clears the accumulator's sums and pair count.
// A stalled result stays in the output register; one more finished result
// waits in the divider, and after that the input side backs up.
`include "vector_cosine_similarity_top_defines.svh"

module vector_cosine_similarity_top import vcs_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vcs_in_if.sink     samples,
	vcs_out_if.source  results
);

	logic      hand_valid;
	logic      hand_ready;
	vcs_snap_t snap;
	logic      fin_valid;
	logic      fin_ready;
	vcs_res_t  fin_res;
	logic      out_valid_q;
	vcs_res_t  res_q;
	logic      in_take;
	logic      zero_out;
	logic      sim_is_zero;
	logic      sim_in_range;

	vcs_accum #(
		.MAX_LEN (MAX_LEN)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.snap       (snap)
	);

	vcs_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.snap       (snap),
		.res_valid  (fin_valid),
		.res_ready  (fin_ready),
		.res        (fin_res)
	);

	assign fin_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_valid && fin_ready) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			res_q <= fin_res;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.similarity = res_q.similarity;
	assign results.zero_norm  = res_q.zero_norm;
	assign results.too_long   = res_q.too_long;

	assign in_take      = samples.valid && samples.ready;
	assign zero_out     = out_valid_q && res_q.zero_norm;
	assign sim_is_zero  = (res_q.similarity == '0);
	assign sim_in_range = (res_q.similarity <= SIM_MAX) && (res_q.similarity >= SIM_MIN);

	`VCS_ASSERT_SAME(a_zero_norm_sim, zero_out, sim_is_zero, "nonzero similarity on zero norm")
	`VCS_ASSERT_SAME(a_sim_range, out_valid_q, sim_in_range, "similarity out of range")
	`VCS_ASSERT_NEXT(a_busy_after_take, in_take, !samples.ready, "pair taken while busy")
	`VCS_ASSERT_NEXT(a_load_shows, fin_valid && fin_ready, out_valid_q, "result not loaded")

endmodule

// File: bench/tb.sv
module tb import vcs_pkg::*; ();

	localparam int RANDOM_PAIRS = 1750;
	localparam int CALM_PAIRS   = 300;
	localparam int HOLD_CYCLES  = 800;
	localparam int DRAIN_CYCLES = 300;
	localparam int WATCHDOG     = 5_000_000;

	localparam logic signed [ELEM_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [ELEM_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum {STYLE_FULL, STYLE_SMALL, STYLE_EDGE} sample_style_t;
	typedef enum {REL_INDEPENDENT, REL_EQUAL, REL_NEGATED, REL_NOISY, REL_ZERO_X, REL_ZERO_Y}
		pair_relation_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vcs_in_if  samples_if();
	vcs_out_if results_if();

	vector_cosine_similarity_top #(.MAX_LEN(MAX_LEN_DEF)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.results(results_if)
	);

	always #1 clk = ~clk;

	// running sums of the vector being received
	logic signed [DOT_W-1:0] dot_acc;
	logic [ENERGY_W-1:0]     xx_acc;
	logic [ENERGY_W-1:0]     yy_acc;
	int unsigned             pairs_acc;
	logic                    length_over;

	vcs_res_t expected_results[$];

	bit          calm;
	bit          hold_request;
	int unsigned mismatch_count;
	int unsigned pairs_sent;
	int unsigned vectors_sent;
	int unsigned results_checked;
	int unsigned zero_norm_count;
	int unsigned too_long_count;
	int unsigned clamp_count;
	int unsigned input_stall_cycles;

	// largest q in [0, 1.0] with (2q-1)^2 * ex * ey <= (2^15 * mag)^2
	function automatic int q14_ratio(logic [DOT_W-1:0] mag, logic [ENERGY_W-1:0] ex,
		logic [ENERGY_W-1:0] ey);
		logic [255:0] norm_sq;
		logic [255:0] bound;
		logic [255:0] trial;
		logic [63:0]  odd;
		int           lo;
		int           hi;
		int           mid;
		norm_sq = 256'(ex) * 256'(ey);
		bound = 256'(mag) << 15;
		bound = bound * bound;
		lo = 0;
		hi = ONE_Q14;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 64'(2 * mid - 1);
			trial = 256'(odd * odd) * norm_sq;
			if (trial <= bound) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic void clear_sums();
		dot_acc = '0;
		xx_acc = '0;
		yy_acc = '0;
		pairs_acc = 0;
		length_over = 1'b0;
	endfunction

	function automatic void predict_pair(logic signed [ELEM_W-1:0] x, logic signed [ELEM_W-1:0] y,
		logic is_last);
		logic signed [PROD_W-1:0] xy;
		logic signed [PROD_W-1:0] xx;
		logic signed [PROD_W-1:0] yy;
		logic [DOT_W-1:0]         mag;
		logic                     neg;
		vcs_res_t                 res;
		int                       q;
		xy = x * y;
		xx = x * x;
		yy = y * y;
		if (pairs_acc >= MAX_LEN_DEF) begin
			length_over = 1'b1;
		end else begin
			dot_acc = dot_acc + {{(DOT_W - PROD_W){xy[PROD_W-1]}}, xy};
			xx_acc = xx_acc + {{(ENERGY_W - PROD_W){1'b0}}, xx};
			yy_acc = yy_acc + {{(ENERGY_W - PROD_W){1'b0}}, yy};
			pairs_acc++;
		end
		if (!is_last) return;
		res.too_long = length_over;
		if (xx_acc == '0 || yy_acc == '0) begin
			res.similarity = '0;
			res.zero_norm = 1'b1;
		end else begin
			neg = dot_acc[DOT_W-1];
			mag = neg ? -dot_acc : dot_acc;
			q = q14_ratio(mag, xx_acc, yy_acc);
			res.similarity = neg ? -SIM_W'(q) : SIM_W'(q);
			res.zero_norm = 1'b0;
		end
		expected_results.push_back(res);
		vectors_sent++;
		clear_sums();
	endfunction

	// entered and left at a falling edge; valid stays up for a following item
	task automatic send_pair(input logic signed [ELEM_W-1:0] x, input logic signed [ELEM_W-1:0] y,
		input logic is_last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.x_elem <= x;
		samples_if.y_elem <= y;
		samples_if.is_last <= is_last;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		predict_pair(x, y, is_last);
		pairs_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [ELEM_W-1:0] draw_sample(sample_style_t style);
		case (style)
		STYLE_SMALL: return ELEM_W'(int'($urandom_range(0, 16)) - 8);
		STYLE_EDGE: begin
			case ($urandom_range(0, 4))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return -16'sd1;
			3: return 16'sd0;
			default: return 16'sd1;
			endcase
		end
		default: return ELEM_W'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	task automatic send_random_vector(input int unsigned len);
		sample_style_t            style;
		pair_relation_t           relation;
		logic signed [ELEM_W-1:0] x;
		logic signed [ELEM_W-1:0] y;
		style = sample_style_t'($urandom_range(0, 2));
		// zero vectors stay rare
		if ($urandom_range(0, 19) == 0) relation = pair_relation_t'($urandom_range(4, 5));
		else relation = pair_relation_t'($urandom_range(0, 3));
		for (int unsigned i = 0; i < len; i++) begin
			x = draw_sample(style);
			case (relation)
			REL_EQUAL:   y = x;
			REL_NEGATED: y = -x;
			REL_NOISY:   y = x + draw_sample(STYLE_SMALL);
			REL_ZERO_X: begin
				y = x;
				x = '0;
			end
			REL_ZERO_Y:  y = '0;
			default:     y = draw_sample(style);
			endcase
			send_pair(x, y, i == len - 1);
		end
	endtask

	task automatic test_single_pairs();
		send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd0, -16'sd1, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b1);
		send_pair(-16'sd1, 16'sd1, 1'b1);
	endtask

	task automatic test_special_vectors();
		// orthogonal
		send_pair(16'sd3, 16'sd0, 1'b0);
		send_pair(16'sd0, -16'sd7, 1'b1);
		// parallel, hits the upper clamp
		send_pair(16'sd100, 16'sd100, 1'b0);
		send_pair(-16'sd200, -16'sd200, 1'b0);
		send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		// antiparallel
		send_pair(16'sd5, -16'sd5, 1'b0);
		send_pair(16'sd7, -16'sd7, 1'b1);
		// 1/sqrt(2), needs rounding
		send_pair(16'sd1, 16'sd1, 1'b0);
		send_pair(16'sd1, 16'sd0, 1'b1);
		// first vector all zeros
		send_pair(16'sd0, 16'sd5, 1'b0);
		send_pair(16'sd0, -16'sd9, 1'b0);
		send_pair(16'sd0, SAMPLE_MAX, 1'b1);
	endtask

	// stall the result side long enough that the input backs up
	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int v = 0; v < 10; v++) send_random_vector(3);
	endtask

	task automatic test_random_vectors();
		int unsigned start;
		int unsigned len;
		start = pairs_sent;
		while (pairs_sent - start < RANDOM_PAIRS) begin
			if (pairs_sent - start >= RANDOM_PAIRS - CALM_PAIRS) calm = 1'b1;
			case ($urandom_range(0, 19))
			0:        len = $urandom_range(41, 200);
			1, 2, 3,
			4, 5:     len = $urandom_range(9, 40);
			default:  len = $urandom_range(1, 8);
			endcase
			send_random_vector(len);
		end
	endtask

	initial begin
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				results_if.ready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		vcs_res_t want;
		if (arst_n && samples_if.valid && !samples_if.ready) input_stall_cycles++;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: similarity %0d zero_norm %0b too_long %0b",
					results_if.similarity, results_if.zero_norm, results_if.too_long);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.zero_norm) zero_norm_count++;
				if (want.too_long) too_long_count++;
				if (want.similarity == SIM_MAX || want.similarity == SIM_MIN) clamp_count++;
				if (results_if.similarity !== want.similarity) begin
					$error("similarity: expected %0d, got %0d", want.similarity,
						results_if.similarity);
					mismatch_count++;
				end
				if (results_if.zero_norm !== want.zero_norm) begin
					$error("zero_norm: expected %0b, got %0b", want.zero_norm,
						results_if.zero_norm);
					mismatch_count++;
				end
				if (results_if.too_long !== want.too_long) begin
					$error("too_long: expected %0b, got %0b", want.too_long,
						results_if.too_long);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(WATCHDOG);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("** vector_cosine_similarity_top: FAILED **");
		$finish;
	end

	initial begin
		samples_if.valid = 1'b0;
		samples_if.x_elem = '0;
		samples_if.y_elem = '0;
		samples_if.is_last = 1'b0;
		clear_sums();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_single_pairs();
		test_special_vectors();
		test_backpressure();
		test_random_vectors();
		samples_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d pairs in %0d vectors, %0d results checked, %0d mismatches",
			pairs_sent, vectors_sent, results_checked, mismatch_count);
		$display("zero norm %0d, too long %0d, full scale %0d, input stall cycles %0d",
			zero_norm_count, too_long_count, clamp_count, input_stall_cycles);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("** vector_cosine_similarity_top: PASSED **");
		end else begin
			$display("** vector_cosine_similarity_top: FAILED **");
		end
		$finish;
	end

endmodule
